FILE: rtl/hvp_pkg.sv
// ----------------------------------------------------------------------------
// HSV value posterize package
// Shared types and constants for the posterize block and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package hvp_pkg;

   // Widths of the divider operands. The largest dividend is
   // 510*255*255 + 255*255, which fits in 25 bits; the largest divisor is
   // 2*255*255, which fits in 17 bits. Every quotient fits in 9 bits.
   localparam int NUM_W = 25;
   localparam int DEN_W = 17;
   localparam int QUO_W = 9;
   localparam int CNT_W = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEVELS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 1'b1;

   localparam logic [7:0] LEVELS_RESET   = 8'd4;
   localparam logic [2:0] CHANNELS_RESET = 3'd3;
   localparam logic [2:0] CHANNELS_RGBA  = 3'd4;
   localparam logic [7:0] BYTE_MAX       = 8'd255;
   localparam logic [DEN_W-1:0] Q_DIVISOR = 17'd510;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QSTART,
      S_QWAIT,
      S_MUL,
      S_CSTART,
      S_CWAIT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/hvp_if.sv
// ----------------------------------------------------------------------------
// HSV value posterize channels
// Valid/ready channels for pixel requests and posterized pixel responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface hvp_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       start_of_frame;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;

   modport source (output valid, kind, start_of_frame, red_in, green_in, blue_in,
                   alpha_in, input ready);
   modport sink   (input valid, kind, start_of_frame, red_in, green_in, blue_in,
                   alpha_in, output ready);
endinterface

interface hvp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       applied;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, applied,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, applied,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/hsv_value_posterize.sv
// A measure transfer updates the statistics at its own edge and gives no result.
// A passed or black convert transfer presents its result in the cycle after the transfer.
// A quantized convert presents it after the level division and then, for each color,
// the product, divider start, nine-bit division and done steps.
// No new item is taken while a convert is in progress or while its result is held.
// Synchronous active-high reset: levels 4, three channels, min 255, max 0, no result held.
// ----------------------------------------------------------------------------
// HSV value posterize
// Tracks the value range over a measure pass and posterizes V on a convert pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_value_posterize (
   input  wire logic                            clock,
   input  wire logic                            reset,
   hvp_req_if.sink                              req_chan,
   hvp_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [hvp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [hvp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hvp_pkg::*;

   // Configuration registers.
   logic [7:0] levels_ff;
   logic [2:0] channels_ff;

   // Frame statistics.
   logic [7:0] min_ff, min_in;
   logic [7:0] max_ff, max_in;

   // Sequencer and working registers.
   state_type      state_ff, state_in;
   logic [15:0]    lv_ff, lv_in;
   logic [7:0]     q_ff, q_in;
   logic [1:0]     ch_ff, ch_in;
   logic [NUM_W-1:0] prod_ff, prod_in;

   // Result register. The color bytes also hold the input colors while a
   // quantized pixel is in progress: each is read for its product and then
   // overwritten by its quotient.
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic [7:0] alpha_ff, alpha_in;
   logic       applied_ff, applied_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic        req_fire;
   logic        rsp_fire;
   logic [7:0]  v;
   logic [7:0]  spread;
   logic        apply_now;
   logic [7:0]  base_min;
   logic [7:0]  base_max;
   logic [DEN_W-1:0] k510;
   logic [7:0]  chan_sel;
   logic [7:0]  quot_byte;

   div_req_type div_req;
   div_rsp_type div_rsp;

   hvp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------------
   // Handshakes and combinational helpers.
   // ------------------------------------------------------------------------
   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   // V is the largest of the three color bytes.
   always_comb begin
      v = req_chan.red_in;
      if (req_chan.green_in > v) begin
         v = req_chan.green_in;
      end
      if (req_chan.blue_in > v) begin
         v = req_chan.blue_in;
      end
   end

   // Before any measurement the minimum is above the maximum, and the spread
   // then counts as zero. A zero level count never quantizes.
   assign spread    = (max_ff >= min_ff) ? (max_ff - min_ff) : 8'd0;
   assign apply_now = (levels_ff != 8'd0) && (spread > levels_ff);

   // On a measure transfer, a start of frame flag restarts the statistics before this pixel is taken.
   assign base_min = req_chan.start_of_frame ? BYTE_MAX : min_ff;
   assign base_max = req_chan.start_of_frame ? 8'd0 : max_ff;

   // 510*q by shift and subtract.
   assign k510 = {q_ff, 9'd0} - {8'd0, q_ff, 1'b0};

   always_comb begin
      case (ch_ff)
         2'd0:    chan_sel = red_ff;
         2'd1:    chan_sel = green_ff;
         2'd2:    chan_sel = blue_ff;
         default: chan_sel = blue_ff;
      endcase
   end

   // The rounded color never exceeds 255, but the quotient has a ninth bit.
   assign quot_byte = div_rsp.quot[QUO_W-1] ? BYTE_MAX : div_rsp.quot[7:0];

   // ------------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            // A black pixel always gets level zero and so comes out black;
            // it needs no division.
            if (req_fire && req_chan.kind && apply_now && (v != 8'd0)) begin
               state_in = S_QSTART;
            end
         end
         S_QSTART: state_in = S_QWAIT;
         S_QWAIT: begin
            if (div_rsp.done) begin
               state_in = S_MUL;
            end
         end
         S_MUL:    state_in = S_CSTART;
         S_CSTART: state_in = S_CWAIT;
         S_CWAIT: begin
            if (div_rsp.done) begin
               state_in = (ch_ff == 2'd2) ? S_IDLE : S_MUL;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer outputs and datapath register updates.
   // ------------------------------------------------------------------------
   always_comb begin
      min_in       = min_ff;
      max_in       = max_ff;
      lv_in        = lv_ff;
      q_in         = q_ff;
      ch_in        = ch_ff;
      prod_in      = prod_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      alpha_in     = alpha_ff;
      applied_in   = applied_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      div_req      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && !req_chan.kind) begin
               max_in = (v > base_max) ? v : base_max;
               min_in = (v < base_min) ? v : base_min;
            end else if (req_fire) begin
               red_in     = req_chan.red_in;
               green_in   = req_chan.green_in;
               blue_in    = req_chan.blue_in;
               alpha_in   = (channels_ff == CHANNELS_RGBA) ? req_chan.alpha_in : BYTE_MAX;
               applied_in = apply_now;
               lv_in      = 16'(levels_ff) * 16'(v);
               if (!apply_now) begin
                  rsp_valid_in = 1'b1;
               end else if (v == 8'd0) begin
                  red_in       = 8'd0;
                  green_in     = 8'd0;
                  blue_in      = 8'd0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_QSTART: begin
            // q = floor((2*levels*V + spread) / 510)
            div_req.start = 1'b1;
            div_req.num   = NUM_W'({lv_ff, 1'b0}) + NUM_W'(spread);
            div_req.den   = Q_DIVISOR;
         end
         S_QWAIT: begin
            if (div_rsp.done) begin
               q_in  = div_rsp.quot[7:0];
               ch_in = 2'd0;
            end
         end
         S_MUL: begin
            // Dividend 510*q*c + levels*V rounds half up over 2*levels*V.
            prod_in = NUM_W'(k510) * NUM_W'(chan_sel) + NUM_W'(lv_ff);
         end
         S_CSTART: begin
            div_req.start = 1'b1;
            div_req.num   = prod_ff;
            div_req.den   = {lv_ff, 1'b0};
         end
         S_CWAIT: begin
            if (div_rsp.done) begin
               case (ch_ff)
                  2'd0:    red_in   = quot_byte;
                  2'd1:    green_in = quot_byte;
                  default: blue_in  = quot_byte;
               endcase
               if (ch_ff == 2'd2) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff   <= LEVELS_RESET;
         channels_ff <= CHANNELS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEVELS:   levels_ff   <= csr_wdata;
            CSR_CHANNELS: channels_ff <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_ff       <= BYTE_MAX;
         max_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff      <= lv_in;
      q_ff       <= q_in;
      ch_ff      <= ch_in;
      prod_ff    <= prod_in;
      red_ff     <= red_in;
      green_ff   <= green_in;
      blue_ff    <= blue_in;
      alpha_ff   <= alpha_in;
      applied_ff <= applied_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_out   = red_ff;
   assign rsp_chan.green_out = green_ff;
   assign rsp_chan.blue_out  = blue_ff;
   assign rsp_chan.alpha_out = alpha_ff;
   assign rsp_chan.applied   = applied_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_chan.ready)
      else $error("request accepted while a result is held");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_QWAIT || state_ff == S_CWAIT))
      else $error("divider finished outside a wait state");

   a_pass_result_next: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.kind && !apply_now) |=> (rsp_valid_ff && !applied_ff))
      else $error("passed pixel not presented on the next cycle");

   a_stats_ordered: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_chan.kind) |=> (min_ff <= max_ff))
      else $error("minimum above maximum after a measure transfer");

endmodule

`default_nettype wire

FILE: rtl/hvp_div.sv
// ----------------------------------------------------------------------------
// HSV value posterize divider
// Restoring divider, one quotient bit per cycle, nine bits per division.
// ----------------------------------------------------------------------------
`default_nettype none

module hvp_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hvp_pkg::div_req_type div_req,
   output hvp_pkg::div_rsp_type      div_rsp
);
   import hvp_pkg::*;

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ge;

   // The caller guarantees that the quotient fits in QUO_W bits, so the
   // divisor starts shifted up by QUO_W-1 places.
   always_comb begin
      ge      = (rem_ff >= dsh_ff);
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.num;
         dsh_in  = {div_req.den, {(QUO_W-1){1'b0}}};
         quot_in = '0;
         cnt_in  = CNT_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[QUO_W-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

`default_nettype wire

FILE: tb/hvp_tb_pkg.sv
// ----------------------------------------------------------------------------
// HSV value posterize testbench types
// Item kinds and the result record shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hvp_tb_pkg;

   typedef enum logic {
      KIND_MEASURE = 1'b0,
      KIND_CONVERT = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       applied;
   } pixel_result_type;

endpackage

`default_nettype wire

FILE: tb/hvp_checker.sv
// ----------------------------------------------------------------------------
// HSV value posterize checker
// Watches the request, response and register ports, predicts every
// posterized pixel and compares each response transfer against it.
// ----------------------------------------------------------------------------
`default_nettype none

module hvp_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   hvp_req_if                                  req_mon,
   hvp_rsp_if                                  rsp_mon,
   input  wire logic                           csr_we,
   input  wire logic [hvp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hvp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                         mismatch_count,
   output int unsigned                         results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import hvp_pkg::*;
   import hvp_tb_pkg::*;

   logic [7:0]       levels_reg;
   logic [2:0]       channels_reg;
   logic [7:0]       value_min;
   logic [7:0]       value_max;
   int unsigned      errors;
   pixel_result_type expected_pixels[$];

   function automatic logic [7:0] clamp_byte(logic [31:0] x);
      return (x > 32'd255) ? 8'd255 : x[7:0];
   endfunction

   function automatic logic [7:0] scale_channel(logic [31:0] q, logic [7:0] c,
                                                logic [31:0] lv);
      return clamp_byte((32'd510 * q * 32'(c) + lv) / (32'd2 * lv));
   endfunction

   function automatic pixel_result_type posterize_pixel(logic [7:0] r, logic [7:0] g,
                                                        logic [7:0] b, logic [7:0] a);
      logic [7:0]       v;
      logic [7:0]       spread;
      logic [31:0]      lv;
      logic [31:0]      q;
      pixel_result_type o;
      v = (r > g) ? r : g;
      v = (v > b) ? v : b;
      // Before any measurement the minimum sits above the maximum.
      spread = (value_max >= value_min) ? value_max - value_min : 8'd0;
      o.red = r;
      o.green = g;
      o.blue = b;
      o.applied = 1'b0;
      if (levels_reg != 8'd0 && spread > levels_reg) begin
         lv = 32'(levels_reg) * 32'(v);
         q = (32'd2 * lv + 32'(spread)) / 32'd510;
         o.applied = 1'b1;
         if (v == 8'd0) begin
            o.red = clamp_byte((32'd510 * q + 32'(levels_reg)) / (32'd2 * 32'(levels_reg)));
            o.green = o.red;
            o.blue = o.red;
         end else begin
            o.red = scale_channel(q, r, lv);
            o.green = scale_channel(q, g, lv);
            o.blue = scale_channel(q, b, lv);
         end
      end
      o.alpha = (channels_reg == CHANNELS_RGBA) ? a : BYTE_MAX;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin : monitor
      logic [7:0]       v;
      pixel_result_type want;
      if (reset) begin
         levels_reg = LEVELS_RESET;
         channels_reg = CHANNELS_RESET;
         value_min = BYTE_MAX;
         value_max = 8'd0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LEVELS: begin
                  levels_reg = csr_wdata[7:0];
               end
               CSR_CHANNELS: begin
                  channels_reg = csr_wdata[2:0];
               end
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_MEASURE) begin
               v = (req_mon.red_in > req_mon.green_in) ? req_mon.red_in : req_mon.green_in;
               v = (v > req_mon.blue_in) ? v : req_mon.blue_in;
               if (req_mon.start_of_frame) begin
                  value_min = BYTE_MAX;
                  value_max = 8'd0;
               end
               if (v > value_max)
                  value_max = v;
               if (v < value_min)
                  value_min = v;
            end else begin
               expected_pixels.push_back(posterize_pixel(req_mon.red_in, req_mon.green_in,
                                                         req_mon.blue_in, req_mon.alpha_in));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("response transfer with no convert item outstanding");
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_mon.red_out !== want.red)
                  report_mismatch($sformatf("red_out %0d, expected %0d",
                                            rsp_mon.red_out, want.red));
               if (rsp_mon.green_out !== want.green)
                  report_mismatch($sformatf("green_out %0d, expected %0d",
                                            rsp_mon.green_out, want.green));
               if (rsp_mon.blue_out !== want.blue)
                  report_mismatch($sformatf("blue_out %0d, expected %0d",
                                            rsp_mon.blue_out, want.blue));
               if (rsp_mon.alpha_out !== want.alpha)
                  report_mismatch($sformatf("alpha_out %0d, expected %0d",
                                            rsp_mon.alpha_out, want.alpha));
               if (rsp_mon.applied !== want.applied)
                  report_mismatch($sformatf("applied %0b, expected %0b",
                                            rsp_mon.applied, want.applied));
            end
         end
      end
      mismatch_count <= errors;
      results_pending <= expected_pixels.size();
   end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// HSV value posterize testbench
// Streams measure and convert passes through the posterize block under
// several register settings, with random gaps on both channels, and lets
// the checker judge every response transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hvp_pkg::*;
   import hvp_tb_pkg::*;

   // Stimulus stops once this many input items have been sent.
   localparam int unsigned ITEM_TARGET = 1650;
   // Extra idle cycles after the block has drained, before a register write or the end.
   localparam int unsigned SETTLE_CYCLES = 80;
   // Cycles without any transfer or register write before the run is given up.
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           mismatch_count;
   int unsigned           results_pending;
   int unsigned           items_sent;
   int unsigned           quiet_cycles;
   bit                    req_idle_on;
   bit                    rsp_idle_on;
   bit                    hold_results;

   hvp_req_if req_chan ();
   hvp_rsp_if rsp_chan ();

   hsv_value_posterize u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hvp_checker u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offers one pixel and returns at the clock edge where it is transferred.
   // Valid is only lowered when a gap follows, so back-to-back transfers keep
   // it high without a second assignment in the same time step.
   task automatic send_pixel(input item_kind_type kind, input logic sof,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
      int unsigned gap;
      if ($urandom_range(0, 49) == 0)
         req_idle_on = !req_idle_on;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.start_of_frame <= sof;
      req_chan.red_in <= r;
      req_chan.green_in <= g;
      req_chan.blue_in <= b;
      req_chan.alpha_in <= a;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Waits at least one edge so the checker has seen the last transfer, then
   // until no response is outstanding.
   task automatic wait_drained();
      do @(posedge clock); while (results_pending != 0);
   endtask

   // Register writes happen only with the block idle. A measure item leaves
   // nothing outstanding, so extra cycles are allowed before the write.
   task automatic set_config(input logic [7:0] lv, input logic [2:0] ch);
      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_LEVELS;
      csr_wdata <= lv;
      @(posedge clock);
      csr_index <= CSR_CHANNELS;
      csr_wdata <= {5'd0, ch};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic draw_pixel(input logic [7:0] lo, input logic [7:0] hi,
                             output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
      r = 8'($urandom_range(hi, lo));
      g = 8'($urandom_range(hi, lo));
      b = 8'($urandom_range(hi, lo));
   endtask

   // Response side: random stalls per transfer, with stretches of none, and
   // one long hold-off on request so the block backs up onto its input.
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      rsp_idle_on = 1'b1;
      hold_results = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_results) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
         if ($urandom_range(0, 49) == 0)
            rsp_idle_on = !rsp_idle_on;
         stall = rsp_idle_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // The run ends with a failure once nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned n;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  lv;
      logic [2:0]  ch;
      bit          hold_done;

      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.kind <= KIND_MEASURE;
      req_chan.start_of_frame <= 1'b0;
      req_chan.red_in <= 8'd0;
      req_chan.green_in <= 8'd0;
      req_chan.blue_in <= 8'd0;
      req_chan.alpha_in <= 8'd0;
      csr_we <= 1'b0;
      csr_index <= CSR_LEVELS;
      csr_wdata <= '0;
      items_sent = 0;
      req_idle_on = 1'b1;
      hold_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset settings first. A convert before any measurement
      // must pass untouched, and its start flag means nothing.
      send_pixel(KIND_CONVERT, 1'b1, 8'd10, 8'd200, 8'd30, 8'd77);
      // Full spread from black to white.
      send_pixel(KIND_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(KIND_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
      // Black takes the zero-value path; white and saturated colors the usual one.
      send_pixel(KIND_CONVERT, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(KIND_CONVERT, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(KIND_CONVERT, 1'b1, 8'd255, 8'd0, 8'd128, 8'd1);
      send_pixel(KIND_CONVERT, 1'b0, 8'd1, 8'd2, 8'd3, 8'd128);
      send_pixel(KIND_CONVERT, 1'b0, 8'd170, 8'd85, 8'd0, 8'h55);

      // Zero levels never quantize; alpha is carried in RGBA mode.
      set_config(8'd0, CHANNELS_RGBA);
      send_pixel(KIND_CONVERT, 1'b0, 8'd200, 8'd100, 8'd50, 8'hAA);
      // A spread equal to the level count is not enough.
      set_config(8'd255, CHANNELS_RGBA);
      send_pixel(KIND_CONVERT, 1'b0, 8'd255, 8'd254, 8'd1, 8'hFF);
      // A channel count other than four acts as three.
      set_config(8'd254, 3'd7);
      send_pixel(KIND_CONVERT, 1'b0, 8'd128, 8'd64, 8'd32, 8'h12);
      send_pixel(KIND_CONVERT, 1'b0, 8'd0, 8'd0, 8'd0, 8'h00);

      // A single level and a narrow range that grows past it step by step.
      set_config(8'd1, CHANNELS_RGBA);
      send_pixel(KIND_MEASURE, 1'b1, 8'd100, 8'd100, 8'd100, 8'd0);
      send_pixel(KIND_MEASURE, 1'b0, 8'd101, 8'd50, 8'd0, 8'd0);
      send_pixel(KIND_CONVERT, 1'b0, 8'd80, 8'd90, 8'd100, 8'h80);
      send_pixel(KIND_MEASURE, 1'b0, 8'd0, 8'd99, 8'd98, 8'd0);
      send_pixel(KIND_CONVERT, 1'b0, 8'd101, 8'd0, 8'd0, 8'hFE);
      send_pixel(KIND_MEASURE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(KIND_CONVERT, 1'b0, 8'd0, 8'd0, 8'd0, 8'h01);
      send_pixel(KIND_CONVERT, 1'b0, 8'd1, 8'd0, 8'd0, 8'hFF);

      // Random part: mostly proper frames (a measure pass opened by the start
      // flag, then a convert pass), with some frames of mixed noise.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase % 4 == 0) begin
            case ($urandom_range(0, 6))
               0:       lv = 8'd0;
               1:       lv = 8'd1;
               2:       lv = 8'd255;
               3, 4:    lv = 8'($urandom_range(2, 16));
               default: lv = 8'($urandom_range(1, 255));
            endcase
            if ($urandom_range(0, 3) == 0)
               ch = 3'($urandom_range(0, 7));
            else
               ch = $urandom_range(0, 1) ? CHANNELS_RGBA : CHANNELS_RESET;
            set_config(lv, ch);
         end
         // Either the full byte range or a narrow band, so that small spreads
         // that let pixels pass are common too.
         if ($urandom_range(0, 2) == 0) begin
            lo = 8'd0;
            hi = 8'd255;
         end else begin
            lo = 8'($urandom_range(0, 255));
            hi = (lo > 8'd235) ? 8'd255 : lo + 8'($urandom_range(0, 20));
         end
         // The sender pauses until every response is back once in mid-run.
         if (phase == 12)
            wait_drained();
         if ($urandom_range(0, 4) != 0) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               draw_pixel(lo, hi, r, g, b);
               send_pixel(KIND_MEASURE, i == 0, r, g, b, 8'($urandom));
            end
            // The long response hold-off starts while converts keep coming.
            if (phase >= 6 && !hold_done) begin
               hold_results = 1'b1;
               hold_done = 1'b1;
            end
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               draw_pixel(lo, hi, r, g, b);
               send_pixel(KIND_CONVERT, $urandom_range(0, 7) == 0, r, g, b, 8'($urandom));
            end
         end else begin
            n = $urandom_range(1, 16);
            for (int i = 0; i < n; i++) begin
               draw_pixel(8'd0, 8'd255, r, g, b);
               send_pixel($urandom_range(0, 1) ? KIND_CONVERT : KIND_MEASURE,
                          1'($urandom_range(0, 1)), r, g, b, 8'($urandom));
            end
         end
         phase++;
      end

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
